@@ sv/srr_pkg.sv @@
// ============================================================================
// srr_pkg: shared definitions for the selective-repeat receiver
// Window geometry, field widths, result kinds and the control state type.
// ============================================================================
package srr_pkg;

  // Window geometry (WINDOW_SIZE must be a power of two, 2 to 64).
  localparam int WINDOW_SIZE  = 8;
  localparam int PAYLOAD_BITS = 32;

  // Fixed field widths of the ports.
  localparam int SEQ_BITS  = 16;
  localparam int DATA_BITS = 32;

  // Bits actually kept per stored payload.
  localparam int STORE_BITS = (PAYLOAD_BITS < DATA_BITS) ? PAYLOAD_BITS : DATA_BITS;

  // Slot index and drain counter widths.
  localparam int SLOT_BITS = $clog2(WINDOW_SIZE);
  localparam int CNT_BITS  = $clog2(WINDOW_SIZE + 1);

  // Result kinds.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_LOOK,
    S_DRAIN
  } state_t;

endpackage

@@ sv/selective_repeat_receiver.sv @@
// ============================================================================
// selective_repeat_receiver: selective-repeat receive window
// Buffers out-of-order packets in a slot RAM, delivers in-order runs and
// produces one acknowledgement per packet.
// ============================================================================
//
//  Channel  Signals                                   Beat carries
//  -------  ----------------------------------------  -------------------------
//  packet   pkt_valid / pkt_ready                     sequence_number, payload
//  result   res_valid / res_ready                     result_kind,
//                                                     delivered_payload,
//                                                     ack_number, last_of_run
//
//  A packet that is not at the window base is taken in S_IDLE, then
//  classified in S_DECIDE, which loads the result register.
//  A packet at the base is delivered from S_DECIDE. Each buffered payload
//  drained then takes a slot RAM read in S_LOOK and a delivery in S_DRAIN,
//  as the slot RAM read is registered; S_LOOK loads the final acknowledgement.
//  Reset is synchronous and clears the base, the slot valid bits and the
//  control state at once; the slot RAM itself is not cleared.
//  A stall on the result side holds the sequencer in any step that loads the
//  result register; the result register lets the next packet beat be taken
//  while the last result is still waiting.
//
module selective_repeat_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pkt_valid,
  output logic                          pkt_ready,
  input  logic [srr_pkg::SEQ_BITS-1:0]  sequence_number,
  input  logic [srr_pkg::DATA_BITS-1:0] payload,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          result_kind,
  output logic [srr_pkg::DATA_BITS-1:0] delivered_payload,
  output logic [srr_pkg::SEQ_BITS-1:0]  ack_number,
  output logic                          last_of_run
);

  srr_pkg::state_t state, state_next;

  // Window state. The payload store lives in the slot RAM.
  logic [srr_pkg::SEQ_BITS-1:0]    base;
  logic [srr_pkg::WINDOW_SIZE-1:0] slot_valid;
  logic [srr_pkg::CNT_BITS-1:0]    cnt;

  // The packet being handled.
  logic [srr_pkg::SEQ_BITS-1:0]   seq_r;
  logic [srr_pkg::STORE_BITS-1:0] pay_r;

  // Classification of the held packet against the window.
  logic [srr_pkg::SEQ_BITS-1:0]  seq_gap;
  logic                          at_base;
  logic                          in_window;
  logic                          beyond;
  logic [srr_pkg::SLOT_BITS-1:0] base_slot;
  logic [srr_pkg::SLOT_BITS-1:0] seq_slot;

  // Sequencer strobes.
  logic                          out_free;
  logic                          load;
  logic                          ld_kind;
  logic [srr_pkg::DATA_BITS-1:0] ld_data;
  logic [srr_pkg::SEQ_BITS-1:0]  ld_ack;
  logic                          base_inc;
  logic                          wr_en;
  logic                          rd_en;
  logic                          clr_slot;
  logic                          cnt_init;
  logic                          cnt_inc;

  logic [srr_pkg::STORE_BITS-1:0] rd_data;

  assign seq_gap   = seq_r - base;
  assign at_base   = (seq_gap == '0);
  assign in_window = (seq_gap < srr_pkg::SEQ_BITS'(srr_pkg::WINDOW_SIZE));
  // Forward distances below half the sequence space lie ahead of the window.
  assign beyond    = ~seq_gap[srr_pkg::SEQ_BITS-1];
  assign base_slot = base[srr_pkg::SLOT_BITS-1:0];
  assign seq_slot  = seq_r[srr_pkg::SLOT_BITS-1:0];

  // The result register can take a new beat when empty or being emptied.
  assign out_free = ~res_valid | res_ready;

  srr_slot_ram #(
    .WIDTH     (srr_pkg::STORE_BITS),
    .ADDR_BITS (srr_pkg::SLOT_BITS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (seq_slot),
    .wr_data (pay_r),
    .rd_en   (rd_en),
    .rd_addr (base_slot),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer. Writes to the slot RAM happen only while classifying and
  // reads only in S_LOOK, so the two never touch one entry together.
  always_comb begin
    state_next = state;
    pkt_ready  = 1'b0;
    load       = 1'b0;
    ld_kind    = srr_pkg::KIND_ACK;
    ld_data    = '0;
    ld_ack     = '0;
    base_inc   = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    clr_slot   = 1'b0;
    cnt_init   = 1'b0;
    cnt_inc    = 1'b0;
    case (state)
      srr_pkg::S_IDLE: begin
        pkt_ready = 1'b1;
        if (pkt_valid) begin
          state_next = srr_pkg::S_DECIDE;
        end
      end
      srr_pkg::S_DECIDE: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = srr_pkg::S_IDLE;
          if (at_base) begin
            // Deliver this payload, then look for a buffered run behind it.
            ld_kind    = srr_pkg::KIND_DELIVER;
            ld_data    = srr_pkg::DATA_BITS'(pay_r);
            base_inc   = 1'b1;
            cnt_init   = 1'b1;
            state_next = srr_pkg::S_LOOK;
          end else if (in_window) begin
            wr_en  = 1'b1;
            ld_ack = seq_r;
          end else if (beyond) begin
            ld_ack = base;
          end else begin
            ld_ack = seq_r;
          end
        end
      end
      srr_pkg::S_LOOK: begin
        if (slot_valid[base_slot] &&
            (cnt < srr_pkg::CNT_BITS'(srr_pkg::WINDOW_SIZE))) begin
          rd_en      = 1'b1;
          state_next = srr_pkg::S_DRAIN;
        end else if (out_free) begin
          load       = 1'b1;
          ld_ack     = base;
          state_next = srr_pkg::S_IDLE;
        end
      end
      srr_pkg::S_DRAIN: begin
        if (out_free) begin
          load       = 1'b1;
          ld_kind    = srr_pkg::KIND_DELIVER;
          ld_data    = srr_pkg::DATA_BITS'(rd_data);
          base_inc   = 1'b1;
          clr_slot   = 1'b1;
          cnt_inc    = 1'b1;
          state_next = srr_pkg::S_LOOK;
        end
      end
      default: begin
        state_next = srr_pkg::S_IDLE;
      end
    endcase
  end

  // Control state: base, valid bits, drain counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      slot_valid <= '0;
      cnt        <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (base_inc) begin
        base <= base + 1'b1;
      end
      if (wr_en) begin
        slot_valid[seq_slot] <= 1'b1;
      end
      if (clr_slot) begin
        slot_valid[base_slot] <= 1'b0;
      end
      if (cnt_init) begin
        cnt <= srr_pkg::CNT_BITS'(1);
      end else if (cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pkt_valid && pkt_ready) begin
      seq_r <= sequence_number;
      pay_r <= payload[srr_pkg::STORE_BITS-1:0];
    end
    if (load) begin
      result_kind       <= ld_kind;
      delivered_payload <= ld_data;
      ack_number        <= ld_ack;
      last_of_run       <= (ld_kind == srr_pkg::KIND_ACK);
    end
  end

  // A drain step only ever reads a slot that holds a buffered payload.
  a_drain_valid: assert property (@(posedge clk) disable iff (rst)
    (state == srr_pkg::S_DRAIN) |-> slot_valid[base_slot])
    else $error("draining a slot that is not valid");

  // The drain never runs past the window.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= srr_pkg::CNT_BITS'(srr_pkg::WINDOW_SIZE))
    else $error("drain counter beyond window size");

  // The base moves only together with an in-order delivery.
  a_base_delivery: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (base != $past(base))) |->
      (res_valid && (result_kind == srr_pkg::KIND_DELIVER)))
    else $error("window base moved without a delivery");

  // A taken packet beat is always classified next.
  a_take_decide: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && pkt_ready) |=> (state == srr_pkg::S_DECIDE))
    else $error("packet beat taken outside idle");

endmodule

@@ sv/srr_slot_ram.sv @@
// ============================================================================
// srr_slot_ram: slot payload store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module srr_slot_ram #(
  parameter int WIDTH     = 32,
  parameter int ADDR_BITS = 3
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ bench/srr_window_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// srr_window_checker: result checker for the selective-repeat receiver
// Watches both channels, keeps its own copy of the receive window, works out
// the results of each packet beat and compares every result beat with them.
// ============================================================================
module srr_window_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pkt_valid,
  input  logic                          pkt_ready,
  input  logic [srr_pkg::SEQ_BITS-1:0]  sequence_number,
  input  logic [srr_pkg::DATA_BITS-1:0] payload,
  input  logic                          res_valid,
  input  logic                          res_ready,
  input  logic                          result_kind,
  input  logic [srr_pkg::DATA_BITS-1:0] delivered_payload,
  input  logic [srr_pkg::SEQ_BITS-1:0]  ack_number,
  input  logic                          last_of_run,
  output int                            fail_count,
  output int                            outstanding,
  output int                            delivery_count,
  output int                            ack_count
);

  typedef struct packed {
    logic                          kind;
    logic [srr_pkg::DATA_BITS-1:0] word;
    logic [srr_pkg::SEQ_BITS-1:0]  ackno;
    logic                          last;
  } rx_result_t;

  localparam logic [srr_pkg::DATA_BITS-1:0] KEEP_MASK =
    {srr_pkg::DATA_BITS{1'b1}} >> (srr_pkg::DATA_BITS - srr_pkg::STORE_BITS);
  localparam logic [srr_pkg::SEQ_BITS-1:0] HALF_SPACE =
    {1'b1, {(srr_pkg::SEQ_BITS-1){1'b0}}};

  // Shadow copy of the window.
  logic [srr_pkg::SEQ_BITS-1:0]  base_seq;
  logic                          slot_full [srr_pkg::WINDOW_SIZE];
  logic [srr_pkg::DATA_BITS-1:0] slot_word [srr_pkg::WINDOW_SIZE];

  rx_result_t expected_results [$];
  rx_result_t want;

  initial begin
    fail_count     = 0;
    outstanding    = 0;
    delivery_count = 0;
    ack_count      = 0;
  end

  // Appends one predicted beat at the tail of the queue.
  task automatic queue_result(input rx_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Works out the beats that one packet causes and updates the shadow window.
  task automatic absorb_packet(input logic [srr_pkg::SEQ_BITS-1:0] seq,
                               input logic [srr_pkg::DATA_BITS-1:0] word);
    logic [srr_pkg::SEQ_BITS-1:0]  gap;
    logic [srr_pkg::SLOT_BITS-1:0] idx;
    int                            drained;
    gap = seq - base_seq;
    if (gap == '0) begin
      queue_result('{srr_pkg::KIND_DELIVER, word & KEEP_MASK, '0, 1'b0});
      base_seq = base_seq + 1'b1;
      drained  = 1;
      idx      = base_seq[srr_pkg::SLOT_BITS-1:0];
      while (drained < srr_pkg::WINDOW_SIZE && slot_full[idx]) begin
        queue_result('{srr_pkg::KIND_DELIVER, slot_word[idx], '0, 1'b0});
        slot_full[idx] = 1'b0;
        base_seq       = base_seq + 1'b1;
        idx            = base_seq[srr_pkg::SLOT_BITS-1:0];
        drained++;
      end
      queue_result('{srr_pkg::KIND_ACK, '0, base_seq, 1'b1});
    end else if (gap < srr_pkg::WINDOW_SIZE) begin
      idx            = seq[srr_pkg::SLOT_BITS-1:0];
      slot_word[idx] = word & KEEP_MASK;
      slot_full[idx] = 1'b1;
      queue_result('{srr_pkg::KIND_ACK, '0, seq, 1'b1});
    end else if (gap < HALF_SPACE) begin
      queue_result('{srr_pkg::KIND_ACK, '0, base_seq, 1'b1});
    end else begin
      queue_result('{srr_pkg::KIND_ACK, '0, seq, 1'b1});
    end
  endtask

  task automatic check_field(input string name,
                             input logic [srr_pkg::DATA_BITS-1:0] exp_val,
                             input logic [srr_pkg::DATA_BITS-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      base_seq = '0;
      for (int i = 0; i < srr_pkg::WINDOW_SIZE; i++) slot_full[i] = 1'b0;
      expected_results.delete();
    end else begin
      // A result beat always belongs to an earlier packet, so it is checked
      // before any packet taken at the same edge is predicted.
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: kind %0d, data %0h, ack %0h",
                 result_kind, delivered_payload, ack_number);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", srr_pkg::DATA_BITS'(want.kind),
                      srr_pkg::DATA_BITS'(result_kind));
          check_field("delivered_payload", want.word, delivered_payload);
          check_field("ack_number", srr_pkg::DATA_BITS'(want.ackno),
                      srr_pkg::DATA_BITS'(ack_number));
          check_field("last_of_run", srr_pkg::DATA_BITS'(want.last),
                      srr_pkg::DATA_BITS'(last_of_run));
          if (want.kind == srr_pkg::KIND_DELIVER) delivery_count++;
          else ack_count++;
        end
      end
      if (pkt_valid && pkt_ready) absorb_packet(sequence_number, payload);
    end
    outstanding = expected_results.size();
  end

endmodule

@@ bench/selective_repeat_receiver_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// selective_repeat_receiver_tb: testbench for the selective-repeat receiver
// Drives packet beats (a directed opening, then shuffled windows mixed with
// stray sequence numbers) under random idling on both channels; the checker
// beside the block predicts and compares every result beat.
// ============================================================================
module selective_repeat_receiver_tb;

  localparam int TOTAL_PACKETS = 170;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 3 * srr_pkg::WINDOW_SIZE + 8;
  localparam logic [srr_pkg::SEQ_BITS-1:0] HALF_SPACE =
    {1'b1, {(srr_pkg::SEQ_BITS-1){1'b0}}};

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          pkt_valid = 1'b0;
  logic                          pkt_ready;
  logic [srr_pkg::SEQ_BITS-1:0]  sequence_number = '0;
  logic [srr_pkg::DATA_BITS-1:0] payload = '0;
  logic                          res_valid;
  logic                          res_ready = 1'b0;
  logic                          result_kind;
  logic [srr_pkg::DATA_BITS-1:0] delivered_payload;
  logic [srr_pkg::SEQ_BITS-1:0]  ack_number;
  logic                          last_of_run;

  int fail_count;
  int outstanding;
  int delivery_count;
  int ack_count;

  // When set, neither side idles: the packet source sends back to back and the
  // result sink keeps ready high.
  logic steady = 1'b0;
  int   sent_count = 0;
  int   cycle_count = 0;

  selective_repeat_receiver u_top (
    .clk               (clk),
    .rst               (rst),
    .pkt_valid         (pkt_valid),
    .pkt_ready         (pkt_ready),
    .sequence_number   (sequence_number),
    .payload           (payload),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .result_kind       (result_kind),
    .delivered_payload (delivered_payload),
    .ack_number        (ack_number),
    .last_of_run       (last_of_run)
  );

  srr_window_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .pkt_valid         (pkt_valid),
    .pkt_ready         (pkt_ready),
    .sequence_number   (sequence_number),
    .payload           (payload),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .result_kind       (result_kind),
    .delivered_payload (delivered_payload),
    .ack_number        (ack_number),
    .last_of_run       (last_of_run),
    .fail_count        (fail_count),
    .outstanding       (outstanding),
    .delivery_count    (delivery_count),
    .ack_count         (ack_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result sink drops ready at random, with a chance of three in ten, outside
  // the steady stretch. Ready is free to drop at any point, including in a drain.
  always @(negedge clk) begin
    res_ready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // Watchdog: ends the run if the block stops making progress.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Presents one packet beat and holds it until the block takes it. Idle
  // cycles are inserted in front of the beat at random unless the steady
  // stretch is in force. Inputs change only at the falling edge.
  task automatic send_packet(input logic [srr_pkg::SEQ_BITS-1:0] seq,
                             input logic [srr_pkg::DATA_BITS-1:0] word);
    while (!steady && $urandom_range(0, 99) < 30) begin
      pkt_valid <= 1'b0;
      @(negedge clk);
    end
    pkt_valid       <= 1'b1;
    sequence_number <= seq;
    payload         <= word;
    @(posedge clk);
    while (!pkt_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // Mostly random words, with all-zero and all-one words now and then.
  function automatic logic [srr_pkg::DATA_BITS-1:0] pick_payload();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return srr_pkg::DATA_BITS'($urandom);
  endfunction

  // A sequence number that can never land at the base or inside the window,
  // given that the real base lies between the anchor and anchor + WINDOW_SIZE.
  // Such packets are acknowledged but leave the window untouched.
  function automatic logic [srr_pkg::SEQ_BITS-1:0] stray_seq(
    input logic [srr_pkg::SEQ_BITS-1:0] anchor);
    logic [srr_pkg::SEQ_BITS-1:0] s;
    logic [srr_pkg::SEQ_BITS-1:0] gap;
    case ($urandom_range(0, 3))
      0: s = anchor -
             srr_pkg::SEQ_BITS'($urandom_range(1, 2 * srr_pkg::WINDOW_SIZE));
      1: s = anchor + srr_pkg::SEQ_BITS'($urandom_range(2 * srr_pkg::WINDOW_SIZE,
                                                        6 * srr_pkg::WINDOW_SIZE));
      // Around the half-space boundary, where beyond turns into behind.
      2: s = anchor + HALF_SPACE +
             srr_pkg::SEQ_BITS'($urandom_range(0, 2 * srr_pkg::WINDOW_SIZE));
      default: begin
        s   = srr_pkg::SEQ_BITS'($urandom);
        gap = s - anchor;
        if (gap < 2 * srr_pkg::WINDOW_SIZE) s = s ^ HALF_SPACE;
      end
    endcase
    return s;
  endfunction

  logic [srr_pkg::SEQ_BITS-1:0] tx_base;
  logic [srr_pkg::SEQ_BITS-1:0] round_seq [0:2*srr_pkg::WINDOW_SIZE-1];
  logic [srr_pkg::SEQ_BITS-1:0] swap_seq;
  int                           round_len;
  int                           beat_total;
  int                           pick_idx;
  int                           round_count = 0;

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- Directed opening -------------------------------------------------
    // Packet at the base of an empty window, with an all-zero word.
    send_packet(16'd0, 32'h0000_0000);
    // The same number again now sits one behind the base.
    send_packet(16'd0, 32'hFFFF_FFFF);
    // Exactly one window ahead of the base: beyond, so the base is acknowledged.
    send_packet(16'd9, 32'h1234_5678);
    // Furthest point still counted as beyond, then the first one counted as behind.
    send_packet(16'h8000, 32'h8765_4321);
    send_packet(16'h8001, 32'hDEAD_BEEF);
    send_packet(16'hFFFF, 32'hFFFF_FFFF);
    // Fill every slot ahead of the base, the far edge of the window first.
    send_packet(16'd8, 32'hFFFF_FFFF);
    for (int s = 2; s < srr_pkg::WINDOW_SIZE; s++) begin
      send_packet(srr_pkg::SEQ_BITS'(s), {16'hA5C3, 16'(s)});
    end
    // A duplicate overwrites the buffered copy.
    send_packet(16'd3, 32'h5A5A_5A5A);
    // The missing packet at the base releases the longest possible run.
    send_packet(16'd1, 32'h8000_0001);
    // A short run of two, then a lone in-order packet.
    send_packet(16'd10, 32'h0F0F_0F0F);
    send_packet(16'd9, 32'hF0F0_F0F0);
    send_packet(16'd11, 32'hFFFF_FFFF);
    tx_base = 16'd12;

    // ---- Random windows ---------------------------------------------------
    // Each round sends every number of a window of random length in shuffled
    // order, sometimes with a repeat, with stray numbers mixed in. The base
    // therefore ends each round exactly at the start of the next one.
    while (sent_count < TOTAL_PACKETS) begin
      round_len  = $urandom_range(1, srr_pkg::WINDOW_SIZE);
      beat_total = round_len;
      for (int i = 0; i < round_len; i++) begin
        round_seq[i] = tx_base + srr_pkg::SEQ_BITS'(i);
      end
      if ($urandom_range(0, 4) == 0) begin
        round_seq[beat_total] = tx_base +
                                srr_pkg::SEQ_BITS'($urandom_range(0, round_len - 1));
        beat_total++;
      end
      for (int i = beat_total - 1; i > 0; i--) begin
        pick_idx            = $urandom_range(0, i);
        swap_seq            = round_seq[i];
        round_seq[i]        = round_seq[pick_idx];
        round_seq[pick_idx] = swap_seq;
      end
      for (int i = 0; i < beat_total; i++) begin
        steady = (sent_count >= 70 && sent_count < 110);
        if ($urandom_range(0, 4) == 0) send_packet(stray_seq(tx_base), pick_payload());
        send_packet(round_seq[i], pick_payload());
      end
      tx_base = tx_base + srr_pkg::SEQ_BITS'(round_len);
      round_count++;
    end
    steady    = 1'b0;
    pkt_valid <= 1'b0;

    // Let every predicted beat arrive, then give the block time to show any
    // stray result before the verdict.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d packets over %0d shuffled windows plus a directed opening.",
             sent_count, round_count);
    $display("Checked %0d in-order deliveries and %0d acknowledgements.",
             delivery_count, ack_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/srr_pkg.sv
sv/srr_slot_ram.sv
sv/selective_repeat_receiver.sv
bench/srr_window_checker.sv
bench/selective_repeat_receiver_tb.sv
